### hw/rtl/assert_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold on the edge after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/mpg_pkg.sv
// ----------------------------------------------------------------------------
// mpg_pkg
// Types, codes and division helpers of the multiset permutation generator.
// ----------------------------------------------------------------------------
package mpg_pkg;

	localparam int LETTER_W = 5;
	localparam int COUNT_W  = 4;
	localparam int TOTAL_W  = 16;
	localparam int ARR_W    = 40;

	typedef struct packed {
		logic                action;
		logic [LETTER_W-1:0] letter;
		logic                first;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [ARR_W-1:0]   arrangement;
		logic [COUNT_W-1:0] length;
		logic [TOTAL_W-1:0] total;
	} result_t;

	typedef enum logic [1:0] {
		RES_LOADED   = 2'd0,
		RES_GIVEN    = 2'd1,
		RES_FINISHED = 2'd2,
		RES_OVERFLOW = 2'd3
	} res_status_t;

	typedef enum logic [0:0] {
		ACT_LOAD = 1'b0,
		ACT_NEXT = 1'b1
	} action_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INSERT,
		S_MUL,
		S_DIV,
		S_PIVOT,
		S_RDP,
		S_FINDQ,
		S_RDA,
		S_RDB,
		S_WRITE,
		S_CHECK,
		S_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_TAKE,
		OP_INSERT,
		OP_MUL,
		OP_DIV,
		OP_PIVOT,
		OP_READ_A,
		OP_READ_B,
		OP_FINDQ,
		OP_SWAP_PIV,
		OP_SWAP_REV,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t      op;
		res_status_t status;
	} cmd_t;

	typedef struct packed {
		logic action;
		logic full;
		logic empty;
		logic has_pivot;
		logic a_lt_b;
	} stat_t;

	// exact division by a multiplicity of 1..8: shift out the power of two,
	// then multiply by the inverse of the odd part modulo 2^16
	function automatic logic [1:0] div_shift(input logic [COUNT_W-1:0] m);
		logic [1:0] s;
		case (m)
			4'd2, 4'd6: s = 2'd1;
			4'd4:       s = 2'd2;
			4'd8:       s = 2'd3;
			default:    s = 2'd0;
		endcase
		return s;
	endfunction

	function automatic logic [TOTAL_W-1:0] div_inv(input logic [COUNT_W-1:0] m);
		logic [TOTAL_W-1:0] v;
		case (m)
			4'd3, 4'd6: v = 16'd43691;
			4'd5:       v = 16'd52429;
			4'd7:       v = 16'd28087;
			default:    v = 16'd1;
		endcase
		return v;
	endfunction

endpackage

### hw/rtl/mpg_datapath.sv
// ----------------------------------------------------------------------------
// mpg_datapath
// Letter store, sorted insert, arrangement count and next-arrangement steps.
// ----------------------------------------------------------------------------
module mpg_datapath #(
	parameter int MAX_LETTERS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mpg_pkg::item_t   item,
	input  mpg_pkg::cmd_t    cmd,
	output mpg_pkg::stat_t   stat,
	output mpg_pkg::result_t result
);

	localparam int IDX_W = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
	localparam int LW    = mpg_pkg::LETTER_W;
	localparam int CW    = mpg_pkg::COUNT_W;
	localparam int TW    = mpg_pkg::TOTAL_W;

	mpg_pkg::item_t   item_q;
	logic [LW-1:0]    letters_q [MAX_LETTERS];
	logic [CW-1:0]    count_q;
	logic [TW-1:0]    total_q;
	logic [CW-1:0]    mult_q;
	logic [TW-1:0]    prod_q;
	logic [IDX_W-1:0] a_q;
	logic [IDX_W-1:0] b_q;
	logic [LW-1:0]    rdat_q;
	logic [LW-1:0]    hold_q;
	mpg_pkg::result_t result_q;

	logic [CW-1:0]          count_eff;
	logic [MAX_LETTERS-1:0] le_vec;
	logic [MAX_LETTERS-1:0] eq_vec;
	logic [CW-1:0]          pos;
	logic [CW-1:0]          mult_new;
	logic [LW-1:0]          ins_val [MAX_LETTERS];
	logic [MAX_LETTERS-1:0] asc;
	logic [IDX_W-1:0]       piv_idx;
	logic [MAX_LETTERS-1:0] gt;
	logic [IDX_W-1:0]       q_idx;
	logic [IDX_W-1:0]       rd_addr;
	logic [mpg_pkg::ARR_W-1:0] packed_arr;
	logic [2*TW-1:0]        quot_full;

	assign count_eff = item_q.first ? '0 : count_q;

	// sorted insert: entries above the slot move up by one
	always_comb begin
		for (int i = 0; i < MAX_LETTERS; i++) begin
			le_vec[i] = (CW'(i) < count_eff) && (letters_q[i] <= item_q.letter);
			eq_vec[i] = (CW'(i) < count_eff) && (letters_q[i] == item_q.letter);
		end
		pos      = CW'($countones(le_vec));
		mult_new = CW'($countones(eq_vec)) + CW'(1);
		for (int i = 0; i < MAX_LETTERS; i++) begin
			if (CW'(i) < pos) begin
				ins_val[i] = letters_q[i];
			end else if (CW'(i) == pos) begin
				ins_val[i] = item_q.letter;
			end else begin
				ins_val[i] = letters_q[(i > 0) ? i - 1 : 0];
			end
		end
	end

	// pivot: highest position followed by a larger letter
	always_comb begin
		asc     = '0;
		piv_idx = '0;
		for (int i = 0; i < MAX_LETTERS - 1; i++) begin
			asc[i] = (CW'(i + 1) < count_q) && (letters_q[i] < letters_q[i + 1]);
			if (asc[i]) begin
				piv_idx = IDX_W'(i);
			end
		end
	end

	// swap partner: highest position past the pivot holding a larger letter
	always_comb begin
		q_idx = '0;
		for (int j = 0; j < MAX_LETTERS; j++) begin
			gt[j] = (CW'(j) < count_q) && (IDX_W'(j) > a_q) && (letters_q[j] > rdat_q);
			if (gt[j]) begin
				q_idx = IDX_W'(j);
			end
		end
	end

	always_comb begin
		packed_arr = '0;
		for (int i = 0; i < MAX_LETTERS; i++) begin
			if (CW'(i) < count_q) begin
				packed_arr[LW*i +: LW] = letters_q[i];
			end
		end
	end

	assign rd_addr   = (cmd.op == mpg_pkg::OP_READ_B) ? b_q : a_q;
	assign quot_full = (prod_q >> mpg_pkg::div_shift(mult_q)) * mpg_pkg::div_inv(mult_q);

	always_ff @(posedge clk) begin
		case (cmd.op)
			mpg_pkg::OP_INSERT: begin
				for (int i = 0; i < MAX_LETTERS; i++) begin
					letters_q[i] <= ins_val[i];
				end
			end
			mpg_pkg::OP_SWAP_PIV, mpg_pkg::OP_SWAP_REV: begin
				letters_q[a_q] <= rdat_q;
				letters_q[b_q] <= hold_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= TW'(1);
		end else begin
			case (cmd.op)
				mpg_pkg::OP_INSERT: begin
					count_q <= count_eff + CW'(1);
					if (item_q.first) begin
						total_q <= TW'(1);
					end
				end
				mpg_pkg::OP_DIV: total_q <= quot_full[TW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			mpg_pkg::OP_TAKE:   item_q <= item;
			mpg_pkg::OP_INSERT: mult_q <= mult_new;
			mpg_pkg::OP_MUL:    prod_q <= TW'(total_q * count_q);
			mpg_pkg::OP_PIVOT:  a_q    <= piv_idx;
			mpg_pkg::OP_FINDQ:  b_q    <= q_idx;
			mpg_pkg::OP_READ_A: rdat_q <= letters_q[rd_addr];
			mpg_pkg::OP_READ_B: begin
				rdat_q <= letters_q[rd_addr];
				hold_q <= rdat_q;
			end
			mpg_pkg::OP_SWAP_PIV: begin
				a_q <= a_q + IDX_W'(1);
				b_q <= IDX_W'(count_q - CW'(1));
			end
			mpg_pkg::OP_SWAP_REV: begin
				a_q <= a_q + IDX_W'(1);
				b_q <= b_q - IDX_W'(1);
			end
			mpg_pkg::OP_EMIT: begin
				result_q.status      <= cmd.status;
				result_q.arrangement <= (cmd.status == mpg_pkg::RES_GIVEN) ? packed_arr : '0;
				result_q.length      <= count_q;
				result_q.total       <= total_q;
			end
			default: begin
			end
		endcase
	end

	assign stat.action    = item_q.action;
	assign stat.full      = (count_eff >= CW'(MAX_LETTERS));
	assign stat.empty     = (count_q == '0);
	assign stat.has_pivot = |asc;
	assign stat.a_lt_b    = (a_q < b_q);
	assign result         = result_q;

endmodule

### hw/rtl/mpg_ctrl.sv
// ----------------------------------------------------------------------------
// mpg_ctrl
// Sequencer: decodes a transaction and steps the datapath through it.
// ----------------------------------------------------------------------------
module mpg_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	output logic           result_valid,
	input  logic           result_stall,
	input  mpg_pkg::stat_t stat,
	output mpg_pkg::cmd_t  cmd
);

	mpg_pkg::state_t      state_q;
	mpg_pkg::state_t      state_d;
	mpg_pkg::res_status_t res_q;
	logic                 started_q;
	logic                 finished_q;
	logic                 piv_q;
	logic                 result_valid_q;
	logic                 emit_ok;

	assign emit_ok = !result_valid_q || !result_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mpg_pkg::S_IDLE: begin
				if (item_valid) begin
					state_d = mpg_pkg::S_DECODE;
				end
			end
			mpg_pkg::S_DECODE: begin
				if (stat.action == mpg_pkg::ACT_LOAD) begin
					state_d = stat.full ? mpg_pkg::S_EMIT : mpg_pkg::S_INSERT;
				end else if (stat.empty || finished_q || !started_q) begin
					state_d = mpg_pkg::S_EMIT;
				end else begin
					state_d = mpg_pkg::S_PIVOT;
				end
			end
			mpg_pkg::S_INSERT: state_d = mpg_pkg::S_MUL;
			mpg_pkg::S_MUL:    state_d = mpg_pkg::S_DIV;
			mpg_pkg::S_DIV:    state_d = mpg_pkg::S_EMIT;
			mpg_pkg::S_PIVOT:  state_d = stat.has_pivot ? mpg_pkg::S_RDP : mpg_pkg::S_EMIT;
			mpg_pkg::S_RDP:    state_d = mpg_pkg::S_FINDQ;
			mpg_pkg::S_FINDQ:  state_d = mpg_pkg::S_RDA;
			mpg_pkg::S_RDA:    state_d = mpg_pkg::S_RDB;
			mpg_pkg::S_RDB:    state_d = mpg_pkg::S_WRITE;
			mpg_pkg::S_WRITE:  state_d = mpg_pkg::S_CHECK;
			mpg_pkg::S_CHECK:  state_d = stat.a_lt_b ? mpg_pkg::S_RDA : mpg_pkg::S_EMIT;
			mpg_pkg::S_EMIT: begin
				if (emit_ok) begin
					state_d = mpg_pkg::S_IDLE;
				end
			end
			default: state_d = mpg_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op     = mpg_pkg::OP_NONE;
		cmd.status = res_q;
		item_stall = (state_q != mpg_pkg::S_IDLE);
		case (state_q)
			mpg_pkg::S_IDLE: begin
				if (item_valid) begin
					cmd.op = mpg_pkg::OP_TAKE;
				end
			end
			mpg_pkg::S_INSERT: cmd.op = mpg_pkg::OP_INSERT;
			mpg_pkg::S_MUL:    cmd.op = mpg_pkg::OP_MUL;
			mpg_pkg::S_DIV:    cmd.op = mpg_pkg::OP_DIV;
			mpg_pkg::S_PIVOT:  cmd.op = mpg_pkg::OP_PIVOT;
			mpg_pkg::S_RDP:    cmd.op = mpg_pkg::OP_READ_A;
			mpg_pkg::S_FINDQ:  cmd.op = mpg_pkg::OP_FINDQ;
			mpg_pkg::S_RDA:    cmd.op = mpg_pkg::OP_READ_A;
			mpg_pkg::S_RDB:    cmd.op = mpg_pkg::OP_READ_B;
			mpg_pkg::S_WRITE:  cmd.op = piv_q ? mpg_pkg::OP_SWAP_PIV : mpg_pkg::OP_SWAP_REV;
			mpg_pkg::S_EMIT: begin
				if (emit_ok) begin
					cmd.op = mpg_pkg::OP_EMIT;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= mpg_pkg::S_IDLE;
			res_q          <= mpg_pkg::RES_LOADED;
			started_q      <= 1'b0;
			finished_q     <= 1'b0;
			piv_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mpg_pkg::S_EMIT && emit_ok) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				mpg_pkg::S_DECODE: begin
					if (stat.action == mpg_pkg::ACT_LOAD) begin
						res_q <= stat.full ? mpg_pkg::RES_OVERFLOW : mpg_pkg::RES_LOADED;
					end else if (stat.empty || finished_q) begin
						res_q <= mpg_pkg::RES_FINISHED;
					end else if (!started_q) begin
						res_q     <= mpg_pkg::RES_GIVEN;
						started_q <= 1'b1;
					end
				end
				mpg_pkg::S_INSERT: begin
					started_q  <= 1'b0;
					finished_q <= 1'b0;
				end
				mpg_pkg::S_PIVOT: begin
					piv_q <= 1'b1;
					if (!stat.has_pivot) begin
						finished_q <= 1'b1;
						res_q      <= mpg_pkg::RES_FINISHED;
					end
				end
				mpg_pkg::S_WRITE: piv_q <= 1'b0;
				mpg_pkg::S_CHECK: res_q <= mpg_pkg::RES_GIVEN;
				default: begin
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;

endmodule

### hw/rtl/multiset_permutation_generator.sv
// ----------------------------------------------------------------------------
// multiset_permutation_generator
// Sorted letter store that steps through its distinct arrangements in order.
// ----------------------------------------------------------------------------
// item channel (item_valid / item_stall / item): a load puts one letter into
// the sorted store (first = 1 empties it beforehand) and updates the count of
// distinct arrangements; a next request gives the following arrangement in
// alphabetical order, starting from the sorted one, then reports finished.
// result channel (result_valid / result_stall / result): one transaction per
// item, carrying status, packed arrangement, length and arrangement count.
// one item is worked on at a time; item_stall is low only while idle.
// a load goes through insert, multiply and divide before its result; a
// refused load or a request answered from the store as it stands goes
// straight to the result, and a request that finds no pivot stops after the
// pivot search; a step makes one letter swap per pass of the sequencer (one
// pivot swap plus up to three for the suffix reversal with eight letters),
// reading through the single read port on the letter store.
// the block is idle again once the result is registered, so a new item
// waits until the previous one has reached the result register.
// a new item is taken while a finished result still waits; its result is
// held back until the previous one has been taken.
// reset empties the store, sets the count to one and drops result_valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multiset_permutation_generator #(
	parameter int MAX_LETTERS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  mpg_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output mpg_pkg::result_t result
);

	mpg_pkg::cmd_t  cmd;
	mpg_pkg::stat_t stat;

	mpg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	mpg_datapath #(
		.MAX_LETTERS (MAX_LETTERS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

	// an accepted transaction keeps the block busy on the next cycle
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item_valid && !item_stall, item_stall, "item accepted twice in a row")

	// length never passes the store depth
	`ASSERT_ALWAYS(a_length_bound, clk, arst_n, !result_valid || (result.length <= 4'(MAX_LETTERS)), "length above store depth")

	// only a given arrangement carries letters
	`ASSERT_ALWAYS(a_arr_zero, clk, arst_n, !result_valid || (result.status == mpg_pkg::RES_GIVEN) || (result.arrangement == '0), "arrangement set without one given")

endmodule

### sim/multiset_permutation_generator_test.sv
// ----------------------------------------------------------------------------
// multiset_permutation_generator_test
// Drives loads and next requests through the item channel and checks every
// result transaction against a predictor of the sorted store and its
// lexicographic stepping, under random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module multiset_permutation_generator_test;

	localparam int MAXL = 8;
	localparam int CYCLE_LIMIT = 900000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	mpg_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	mpg_pkg::result_t result;

	// predictor state
	logic [4:0] store [MAXL];
	int unsigned n_stored = 0;
	logic [15:0] arr_count = 16'd1;
	bit stepping = 0;
	bit exhausted = 0;

	mpg_pkg::result_t pending [$];
	int errors = 0;
	int n_results = 0;
	int n_given = 0;
	int n_overflow = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_recv = 0;

	multiset_permutation_generator dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("multiset_permutation_generator regression: fail");
			$finish;
		end
	end

	function automatic logic [39:0] packed_letters();
		logic [39:0] v;
		v = '0;
		for (int i = 0; i < n_stored; i++)
			v[5*i +: 5] = store[i];
		return v;
	endfunction

	function automatic bit step_lex();
		int p;
		int q;
		int lo;
		int hi;
		logic [4:0] t;
		if (n_stored < 2)
			return 0;
		p = n_stored - 1;
		while (p > 0 && store[p-1] >= store[p])
			p--;
		if (p == 0)
			return 0;
		p--;
		q = n_stored - 1;
		while (store[q] <= store[p])
			q--;
		t = store[p]; store[p] = store[q]; store[q] = t;
		lo = p + 1;
		hi = n_stored - 1;
		while (lo < hi) begin
			t = store[lo]; store[lo] = store[hi]; store[hi] = t;
			lo++;
			hi--;
		end
		return 1;
	endfunction

	function automatic mpg_pkg::result_t predict_result(mpg_pkg::item_t it);
		mpg_pkg::result_t r;
		int mult;
		int j;
		logic [31:0] prod;
		logic [4:0] t;
		r = '0;
		if (it.action == mpg_pkg::ACT_LOAD) begin
			if (it.first) begin
				n_stored = 0;
				arr_count = 16'd1;
			end
			if (n_stored >= MAXL) begin
				r.status = mpg_pkg::RES_OVERFLOW;
			end else begin
				store[n_stored] = it.letter;
				n_stored++;
				for (int i = 1; i < n_stored; i++) begin
					j = i;
					while (j > 0 && store[j-1] > store[j]) begin
						t = store[j-1]; store[j-1] = store[j]; store[j] = t;
						j--;
					end
				end
				mult = 0;
				for (int i = 0; i < n_stored; i++)
					if (store[i] == it.letter)
						mult++;
				prod = arr_count * n_stored;
				arr_count = 16'(prod / mult);
				stepping = 0;
				exhausted = 0;
				r.status = mpg_pkg::RES_LOADED;
			end
		end else begin
			if (n_stored == 0 || exhausted) begin
				r.status = mpg_pkg::RES_FINISHED;
			end else if (!stepping) begin
				stepping = 1;
				r.status = mpg_pkg::RES_GIVEN;
				r.arrangement = packed_letters();
			end else if (step_lex()) begin
				r.status = mpg_pkg::RES_GIVEN;
				r.arrangement = packed_letters();
			end else begin
				exhausted = 1;
				r.status = mpg_pkg::RES_FINISHED;
			end
		end
		r.length = 4'(n_stored);
		r.total = arr_count;
		return r;
	endfunction

	task automatic send_item(logic act, logic [4:0] letter, logic first);
		mpg_pkg::item_t it;
		bit idle;
		it.action = act;
		it.letter = letter;
		it.first = first;
		idle = ($urandom_range(99) < send_idle_pct);
		while (idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
			idle = ($urandom_range(99) < send_idle_pct);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		pending.push_back(predict_result(it));
	endtask

	task automatic release_sender();
		item_valid <= 1'b0;
		@(posedge clk);
	endtask

	// receiver stall
	always @(posedge clk) begin
		if (!arst_n)
			result_stall <= 1'b0;
		else
			result_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
	end

	// result checker
	always @(posedge clk) begin
		mpg_pkg::result_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			n_results++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $time, result);
			end else begin
				exp_r = pending.pop_front();
				if (exp_r.status == mpg_pkg::RES_GIVEN)
					n_given++;
				if (exp_r.status == mpg_pkg::RES_OVERFLOW)
					n_overflow++;
				if (result.status !== exp_r.status) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time,
						exp_r.status, result.status);
				end
				if (result.arrangement !== exp_r.arrangement) begin
					errors++;
					$display("%0t: arrangement expected %h actual %h", $time,
						exp_r.arrangement, result.arrangement);
				end
				if (result.length !== exp_r.length) begin
					errors++;
					$display("%0t: length expected %0d actual %0d", $time,
						exp_r.length, result.length);
				end
				if (result.total !== exp_r.total) begin
					errors++;
					$display("%0t: total expected %0d actual %0d", $time,
						exp_r.total, result.total);
				end
			end
		end
	end

	task automatic walk_all(int max_req);
		for (int i = 0; i < max_req; i++)
			send_item(mpg_pkg::ACT_NEXT, 5'd0, 1'b0);
	endtask

	task automatic test_directed();
		send_item(mpg_pkg::ACT_NEXT, 5'd0, 1'b0);
		send_item(mpg_pkg::ACT_LOAD, 5'd31, 1'b1);
		send_item(mpg_pkg::ACT_LOAD, 5'd0, 1'b0);
		send_item(mpg_pkg::ACT_LOAD, 5'd25, 1'b0);
		send_item(mpg_pkg::ACT_LOAD, 5'd0, 1'b0);
		walk_all(14);
		for (int i = 0; i < 5; i++)
			send_item(mpg_pkg::ACT_LOAD, 5'(26 + i), 1'b0);
		send_item(mpg_pkg::ACT_LOAD, 5'd3, 1'b0);
		send_item(mpg_pkg::ACT_LOAD, 5'd7, 1'b1);
		send_item(mpg_pkg::ACT_NEXT, 5'd0, 1'b0);
		send_item(mpg_pkg::ACT_NEXT, 5'd0, 1'b0);
	endtask

	// full store of distinct letters: total 40320, overflow on a ninth load
	task automatic test_full_store();
		for (int i = 0; i < MAXL; i++)
			send_item(mpg_pkg::ACT_LOAD, 5'(7 - i), i == 0);
		send_item(mpg_pkg::ACT_LOAD, 5'd1, 1'b0);
		walk_all(60);
		for (int i = 0; i < MAXL; i++)
			send_item(mpg_pkg::ACT_LOAD, 5'd9, i == 0);
		walk_all(3);
	endtask

	task automatic test_random(int n_items);
		int done;
		int len;
		int alpha;
		done = 0;
		while (done < n_items) begin
			if ($urandom_range(9) < 8) begin
				len = $urandom_range(1, 4) + ($urandom_range(3) == 0 ? 4 : 0);
				alpha = $urandom_range(3) == 0 ? 32 : $urandom_range(2, 4);
				for (int i = 0; i < len; i++)
					send_item(mpg_pkg::ACT_LOAD, 5'($urandom_range(alpha - 1)), i == 0);
				done += len;
				len = $urandom_range(2, 30);
				walk_all(len);
				done += len;
			end else begin
				send_item(1'($urandom_range(1)), 5'($urandom_range(31)),
					1'($urandom_range(1)));
				done++;
			end
		end
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_recv = 1;
				repeat (300) @(posedge clk);
				hold_recv = 0;
			end
			begin
				send_item(mpg_pkg::ACT_LOAD, 5'd4, 1'b1);
				send_item(mpg_pkg::ACT_LOAD, 5'd2, 1'b0);
				send_item(mpg_pkg::ACT_LOAD, 5'd4, 1'b0);
				walk_all(5);
				release_sender();
			end
		join
	endtask

	task automatic wait_drained();
		release_sender();
		while (pending.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 26;
		recv_idle_pct = 52;
		test_directed();
		test_full_store();
		test_random(600);
		send_idle_pct = 52;
		recv_idle_pct = 26;
		test_backpressure();
		test_random(600);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(600);
		wait_drained();

		$display("covered %0d results: %0d arrangements, %0d refused loads",
			n_results, n_given, n_overflow);
		if (errors == 0)
			$display("multiset_permutation_generator regression: pass");
		else
			$display("multiset_permutation_generator regression: fail");
		$finish;
	end

endmodule
